// File: sv/swdc_pkg.sv
// ----------------------------------------------------------------------------
// swdc_pkg
// Shared types and constants of the sliding window deviation classifier:
// request and result payloads, sequencer states, register map and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package swdc_pkg;

  // window geometry and sample width, fixed by the payload fields
  localparam int unsigned WIN_MAX  = 64;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = $clog2(WIN_MAX);
  localparam int unsigned CNT_W    = $clog2(WIN_MAX + 1);

  // statistics widths
  localparam int unsigned SUM_W    = SAMPLE_W + IDX_W;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W + IDX_W;
  localparam int unsigned SCALED_W = SAMPLE_W + CNT_W;
  localparam int unsigned DIST_W   = SUM_W;
  localparam int unsigned D2_W     = 2 * DIST_W;
  localparam int unsigned VAR_W    = CNT_W + SQ_W;
  localparam int unsigned CMP_W    = VAR_W + 4;

  // configuration port
  localparam int unsigned ADDR_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 7;
  localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH = ADDR_W'(0);
  localparam logic [LEN_W-1:0]  LEN_RESET         = LEN_W'(64);
  localparam logic [LEN_W-1:0]  LEN_MIN           = LEN_W'(2);

  // request opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_FEW = 1'b1;

  localparam logic [2:0] FACTOR_NONE  = 3'd0;
  localparam logic [2:0] FACTOR_ONE   = 3'd1;
  localparam logic [2:0] FACTOR_TWO   = 3'd2;
  localparam logic [2:0] FACTOR_THREE = 3'd3;
  localparam logic [2:0] FACTOR_FOUR  = 3'd4;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [2:0]       factor;
    logic [CNT_W-1:0] sample_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_Q1,
    ST_Q2,
    ST_Q3
  } state_e;

  // sequencer to window store
  typedef struct packed {
    logic rd;
    logic commit;
    logic clear;
  } win_ctrl_t;

  // window store to sequencer and classifier
  typedef struct packed {
    logic [CNT_W-1:0] held;
    logic [CNT_W-1:0] commit_count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sqsum;
  } win_stats_t;

  // sequencer to classifier
  typedef struct packed {
    logic step1;
    logic step2;
  } dev_ctrl_t;

endpackage

`default_nettype wire

// File: sv/swdc_ram.sv
// ----------------------------------------------------------------------------
// swdc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swdc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/swdc_window.sv
// ----------------------------------------------------------------------------
// swdc_window
// Circular sample store with running sum and sum of squares. The oldest
// sample is read on request accept and, once the window is full, evicted in the commit cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swdc_window (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire swdc_pkg::win_ctrl_t                ctrl_i,
  input  wire logic [swdc_pkg::CNT_W-1:0]         len_i,
  input  wire logic [swdc_pkg::SAMPLE_W-1:0]      sample_i,
  output swdc_pkg::win_stats_t                    stats_o
);

  localparam int unsigned SW  = swdc_pkg::SAMPLE_W;
  localparam int unsigned SQW = 2 * SW;
  localparam int unsigned IW  = swdc_pkg::IDX_W;
  localparam int unsigned CW  = swdc_pkg::CNT_W;
  localparam int unsigned UW  = swdc_pkg::SUM_W;
  localparam int unsigned QW  = swdc_pkg::SQ_W;
  localparam int unsigned PW  = IW + 1;

  logic [IW-1:0]   oldest_q, oldest_d;
  logic [CW-1:0]   held_q, held_d;
  logic [UW-1:0]   sum_q, sum_d;
  logic [QW-1:0]   sqsum_q, sqsum_d;
  logic [SW-1:0]   samp_q;
  logic [SQW-1:0]  samp_sq_q;

  logic [SW-1:0]   old_sample;
  logic [SQW-1:0]  old_sq;
  logic            evict;
  logic [PW-1:0]   pos_sum;
  logic [IW-1:0]   wr_pos;
  logic [IW-1:0]   oldest_inc;

  // the write lands after the read and before the next accept, so read
  // and write of the same entry never overlap
  swdc_ram #(
    .WIDTH(SW),
    .DEPTH(swdc_pkg::WIN_MAX)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.commit),
    .waddr_i(wr_pos),
    .wdata_i(samp_q),
    .re_i   (ctrl_i.rd),
    .raddr_i(oldest_q),
    .rdata_o(old_sample)
  );

  // sample and its square are captured with the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      samp_q    <= sample_i;
      samp_sq_q <= SQW'(sample_i) * SQW'(sample_i);
    end
  end

  assign evict  = (held_q >= len_i);
  assign old_sq = SQW'(old_sample) * SQW'(old_sample);

  // slot after the newest sample; same slot whether or not one is evicted
  assign pos_sum = PW'(oldest_q) + PW'(held_q);
  assign wr_pos  = (pos_sum >= PW'(swdc_pkg::WIN_MAX)) ?
                   IW'(pos_sum - PW'(swdc_pkg::WIN_MAX)) : IW'(pos_sum);

  assign oldest_inc = (oldest_q == IW'(swdc_pkg::WIN_MAX - 1)) ? '0 : oldest_q + 1'b1;

  always_comb begin
    oldest_d = oldest_q;
    held_d   = held_q;
    sum_d    = sum_q;
    sqsum_d  = sqsum_q;
    if (ctrl_i.clear) begin
      oldest_d = '0;
      held_d   = '0;
      sum_d    = '0;
      sqsum_d  = '0;
    end else if (ctrl_i.commit) begin
      sum_d   = sum_q + UW'(samp_q) - (evict ? UW'(old_sample) : '0);
      sqsum_d = sqsum_q + QW'(samp_sq_q) - (evict ? QW'(old_sq) : '0);
      if (evict) begin
        oldest_d = oldest_inc;
      end else begin
        held_d = held_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      held_q   <= '0;
      sum_q    <= '0;
      sqsum_q  <= '0;
    end else begin
      oldest_q <= oldest_d;
      held_q   <= held_d;
      sum_q    <= sum_d;
      sqsum_q  <= sqsum_d;
    end
  end

  assign stats_o.held         = held_q;
  assign stats_o.commit_count = evict ? held_q : held_q + 1'b1;
  assign stats_o.sum          = sum_q;
  assign stats_o.sqsum        = sqsum_q;

endmodule

`default_nettype wire

// File: sv/swdc_dev.sv
// ----------------------------------------------------------------------------
// swdc_dev
// Deviation factor datapath: cross-multiplied distance and variance over
// two register stages, then a compare against 1, 4 and 9 times the variance.
// ----------------------------------------------------------------------------
`default_nettype none

module swdc_dev (
  input  wire logic                          clk_i,
  input  wire swdc_pkg::dev_ctrl_t           ctrl_i,
  input  wire logic [swdc_pkg::SAMPLE_W-1:0] amount_i,
  input  wire swdc_pkg::win_stats_t          stats_i,
  output logic [2:0]                         factor_o
);

  localparam int unsigned XW = swdc_pkg::SCALED_W;
  localparam int unsigned DW = swdc_pkg::DIST_W;
  localparam int unsigned EW = swdc_pkg::D2_W;
  localparam int unsigned VW = swdc_pkg::VAR_W;
  localparam int unsigned CW = swdc_pkg::CMP_W;

  logic [XW-1:0] scaled;
  logic [XW-1:0] sum_x;
  logic [XW-1:0] diff;

  logic [DW-1:0] dist_q;
  logic [VW-1:0] p_cs_q;
  logic [EW-1:0] p_ss_q;
  logic [EW-1:0] d2_q;
  logic [VW-1:0] var_q;

  logic [CW-1:0] d2_x, v1, v4, v9;

  // first stage: |amount*cnt - sum|, cnt*sqsum, sum^2
  assign scaled = XW'(amount_i) * XW'(stats_i.held);
  assign sum_x  = XW'(stats_i.sum);
  assign diff   = (scaled >= sum_x) ? scaled - sum_x : sum_x - scaled;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step1) begin
      // both operands stay below WIN_MAX * 2^SAMPLE_W, so the distance fits
      dist_q <= DW'(diff);
      p_cs_q <= VW'(stats_i.held) * VW'(stats_i.sqsum);
      p_ss_q <= EW'(stats_i.sum) * EW'(stats_i.sum);
    end
  end

  // second stage: variance numerator is never negative
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step2) begin
      var_q <= p_cs_q - VW'(p_ss_q);
      d2_q  <= EW'(dist_q) * EW'(dist_q);
    end
  end

  assign d2_x = CW'(d2_q);
  assign v1   = CW'(var_q);
  assign v4   = v1 << 2;
  assign v9   = (v1 << 3) + v1;

  always_comb begin
    if (d2_x < v1) begin
      factor_o = swdc_pkg::FACTOR_ONE;
    end else if (d2_x < v4) begin
      factor_o = swdc_pkg::FACTOR_TWO;
    end else if (d2_x < v9) begin
      factor_o = swdc_pkg::FACTOR_THREE;
    end else begin
      factor_o = swdc_pkg::FACTOR_FOUR;
    end
  end

endmodule

`default_nettype wire

// File: sv/sliding_window_deviation_classifier.sv
// ----------------------------------------------------------------------------
// sliding_window_deviation_classifier
// Sliding window of unsigned samples with a deviation factor query.
// ----------------------------------------------------------------------------
// An add request stores a sample in a 64-entry window held in a synchronous
// RAM, evicting the oldest sample once window_length samples are held; a
// query request classifies a value as 1..4 by how many standard deviations
// it lies from the window mean, or reports status 1 with fewer than two
// samples. Every request gives exactly one result with the sample count
// after it. For an add, the accept cycle issues the RAM read of the oldest
// sample and the ST_ADD state then updates the sums and writes the new
// sample. A query runs through a two-stage multiply sequence (ST_Q1, ST_Q2)
// and a final compare (ST_Q3); a query that fails for too few samples ends
// in ST_Q1. Results wait in an output register, and a request finishes
// only when that register is free. Writing window_length empties the
// window at once; no clearing pass runs after reset.
`default_nettype none

module sliding_window_deviation_classifier (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,

  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire swdc_pkg::in_item_t               in_req_i,

  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output swdc_pkg::out_item_t                   out_rsp_o,

  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [swdc_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [swdc_pkg::DATA_W-1:0]      pwdata,
  output logic      [swdc_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int unsigned CW = swdc_pkg::CNT_W;
  localparam int unsigned LW = swdc_pkg::LEN_W;

  swdc_pkg::state_e     state_q, state_d;
  swdc_pkg::in_item_t   item_q;
  swdc_pkg::out_item_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [LW-1:0]        wlen_q, wlen_d;

  swdc_pkg::win_ctrl_t  win_ctrl;
  swdc_pkg::win_stats_t stats;
  swdc_pkg::dev_ctrl_t  dev_ctrl;
  logic [2:0]           factor;
  logic [CW-1:0]        len_eff;

  logic accept;
  logic out_free;
  logic out_load;
  logic cfg_we;
  logic few;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == swdc_pkg::REG_WINDOW_LENGTH);
  assign wlen_d = cfg_we ? pwdata[LW-1:0] : wlen_q;
  assign prdata = (paddr == swdc_pkg::REG_WINDOW_LENGTH) ?
                  swdc_pkg::DATA_W'(wlen_q) : '0;

  // clamp window length to 2..WIN_MAX
  always_comb begin
    if (wlen_q < swdc_pkg::LEN_MIN) begin
      len_eff = CW'(swdc_pkg::LEN_MIN);
    end else if (CW'(wlen_q) > CW'(swdc_pkg::WIN_MAX)) begin
      len_eff = CW'(swdc_pkg::WIN_MAX);
    end else begin
      len_eff = CW'(wlen_q);
    end
  end

  assign in_ready_o = (state_q == swdc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign few        = (stats.held < CW'(2));

  swdc_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .len_i   (len_eff),
    .sample_i(in_req_i.amount),
    .stats_o (stats)
  );

  swdc_dev u_dev (
    .clk_i   (clk_i),
    .ctrl_i  (dev_ctrl),
    .amount_i(item_q.amount),
    .stats_i (stats),
    .factor_o(factor)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swdc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_req_i.op == swdc_pkg::OP_ADD) ? swdc_pkg::ST_ADD : swdc_pkg::ST_Q1;
        end
      end
      swdc_pkg::ST_ADD: begin
        if (out_free) begin
          state_d = swdc_pkg::ST_IDLE;
        end
      end
      swdc_pkg::ST_Q1: begin
        if (!few) begin
          state_d = swdc_pkg::ST_Q2;
        end else if (out_free) begin
          state_d = swdc_pkg::ST_IDLE;
        end
      end
      swdc_pkg::ST_Q2: begin
        state_d = swdc_pkg::ST_Q3;
      end
      swdc_pkg::ST_Q3: begin
        if (out_free) begin
          state_d = swdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swdc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    win_ctrl.rd     = accept;
    win_ctrl.commit = 1'b0;
    win_ctrl.clear  = cfg_we;
    dev_ctrl.step1  = 1'b0;
    dev_ctrl.step2  = 1'b0;
    out_load        = 1'b0;
    out_d           = out_q;
    unique case (state_q)
      swdc_pkg::ST_IDLE: begin
      end
      swdc_pkg::ST_ADD: begin
        win_ctrl.commit = out_free;
        out_load        = out_free;
        out_d.status       = swdc_pkg::STATUS_OK;
        out_d.factor       = swdc_pkg::FACTOR_NONE;
        out_d.sample_count = stats.commit_count;
      end
      swdc_pkg::ST_Q1: begin
        dev_ctrl.step1 = 1'b1;
        out_load       = few && out_free;
        out_d.status       = swdc_pkg::STATUS_FEW;
        out_d.factor       = swdc_pkg::FACTOR_NONE;
        out_d.sample_count = stats.held;
      end
      swdc_pkg::ST_Q2: begin
        dev_ctrl.step2 = 1'b1;
      end
      swdc_pkg::ST_Q3: begin
        out_load = out_free;
        out_d.status       = swdc_pkg::STATUS_OK;
        out_d.factor       = factor;
        out_d.sample_count = stats.held;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swdc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      wlen_q      <= swdc_pkg::LEN_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      wlen_q      <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: sv/swdc_checker.sv
// ----------------------------------------------------------------------------
// swdc_checker
// Port-level checks of the deviation classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swdc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire swdc_pkg::out_item_t          out_rsp_o
);

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // an error result carries no factor and fewer than two samples
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == swdc_pkg::STATUS_FEW) |->
      (out_rsp_o.factor == swdc_pkg::FACTOR_NONE) && (out_rsp_o.sample_count < 7'd2))
    else $error("bad error result");

  // a classified query needs two samples and a factor of at most four
  a_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.factor != swdc_pkg::FACTOR_NONE) |->
      (out_rsp_o.sample_count >= 7'd2) && (out_rsp_o.factor <= swdc_pkg::FACTOR_FOUR)
      && (out_rsp_o.status == swdc_pkg::STATUS_OK))
    else $error("bad factor result");

  // an accepted request leaves the block busy, so no request is taken back to back
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken back to back");

  // count never exceeds the window size
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.sample_count <= 7'(swdc_pkg::WIN_MAX)))
    else $error("sample count out of range");

endmodule

bind sliding_window_deviation_classifier swdc_checker u_swdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);

`default_nettype wire
